FILE: hdl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared definitions for the positional array list
// Store size, derived widths, operation and status codes, cell actions.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // operation codes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_LOCATE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPOS   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // what a cell does on an accepted word
    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_LOAD,
        ACT_FROM_BELOW,
        ACT_FROM_ABOVE,
        ACT_ZERO
    } cell_act_t;

endpackage

FILE: hdl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell: one list slot
// Holds one entry, takes a neighbour's entry on a shift, compares to the key.
// ----------------------------------------------------------------------------
module pal_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  pal_pkg::cell_act_t                  act,
    input  logic signed [pal_pkg::DATA_W-1:0]   load_data,
    input  logic signed [pal_pkg::DATA_W-1:0]   lower_data,
    input  logic signed [pal_pkg::DATA_W-1:0]   upper_data,
    input  logic signed [pal_pkg::DATA_W-1:0]   key,
    output logic signed [pal_pkg::DATA_W-1:0]   data,
    output logic                                match
);

    logic signed [pal_pkg::DATA_W-1:0] data_reg;
    logic signed [pal_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (act)
            pal_pkg::ACT_HOLD:       data_next = data_reg;
            pal_pkg::ACT_LOAD:       data_next = load_data;
            pal_pkg::ACT_FROM_BELOW: data_next = lower_data;
            pal_pkg::ACT_FROM_ABOVE: data_next = upper_data;
            pal_pkg::ACT_ZERO:       data_next = '0;
            default:                 data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

FILE: hdl/positional_array_list_unit.sv
// ----------------------------------------------------------------------------
// positional_array_list_unit: ordered list of signed 32-bit words
// A row of slot cells that shift up on insert and down on remove.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: func, value_in, position_in with in_valid / in_ready.
//   Each word asks for one operation (insert, remove, get, locate, clear).
//   Output channel: status, value_out, position_out, length_out with
//   out_valid / out_ready; exactly one result word per input word, in order.
// Latency and throughput
//   The result is registered and appears in the cycle after the input word
//   is accepted. All slot cells shift, compare or clear in the same cycle,
//   so the block takes one word per cycle while out_ready keeps up; the
//   figure is set by the single output register that holds the result.
// Reset
//   rst_n clears every slot to zero, the length to zero and the output
//   register to empty. No clearing pass is needed.
// Stall
//   While a result waits and out_ready is low, in_ready drops; when the
//   result is taken, a new word is accepted in the same cycle.
// ----------------------------------------------------------------------------
module positional_array_list_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          func,
    input  logic signed [31:0]                  value_in,
    input  logic [4:0]                          position_in,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          status,
    output logic signed [31:0]                  value_out,
    output logic [3:0]                          position_out,
    output logic [4:0]                          length_out
);

    localparam int CAP = pal_pkg::CAPACITY;

    logic                                   accept;
    logic [pal_pkg::CNT_W-1:0]              count_reg;
    logic [pal_pkg::CNT_W-1:0]              count_next;
    logic                                   out_valid_reg;
    logic [2:0]                             status_reg;
    logic [2:0]                             status_next;
    logic signed [31:0]                     value_reg;
    logic signed [31:0]                     value_next;
    logic [3:0]                             position_reg;
    logic [3:0]                             position_next;
    logic [4:0]                             length_reg;

    pal_pkg::cell_act_t                     act [CAP];
    logic signed [pal_pkg::DATA_W-1:0]      cell_data [CAP];
    logic [CAP-1:0]                         cell_match;

    logic [31:0]                            pos_w;
    logic [31:0]                            cnt_w;
    logic                                   do_insert;
    logic                                   do_remove;
    logic                                   do_clear;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign pos_w    = 32'(position_in);
    assign cnt_w    = 32'(count_reg);

    // ---- operation decode, status and result --------------------------
    always_comb
    begin
        status_next   = pal_pkg::ST_OK;
        value_next    = '0;
        position_next = '0;
        count_next    = count_reg;
        do_insert     = 1'b0;
        do_remove     = 1'b0;
        do_clear      = 1'b0;
        case (func)
            pal_pkg::OP_INSERT:
            begin
                if (pos_w > cnt_w)
                    status_next = pal_pkg::ST_BADPOS;
                else if (cnt_w >= 32'(CAP))
                    status_next = pal_pkg::ST_FULL;
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + pal_pkg::CNT_W'(1);
                end
            end
            pal_pkg::OP_REMOVE:
            begin
                if (count_reg == '0)
                    status_next = pal_pkg::ST_EMPTY;
                else if (pos_w >= cnt_w)
                    status_next = pal_pkg::ST_BADPOS;
                else
                begin
                    do_remove  = 1'b1;
                    count_next = count_reg - pal_pkg::CNT_W'(1);
                end
            end
            pal_pkg::OP_GET:
            begin
                if (count_reg == '0)
                    status_next = pal_pkg::ST_EMPTY;
                else if (pos_w >= cnt_w)
                    status_next = pal_pkg::ST_BADPOS;
                else
                    value_next = cell_data[pal_pkg::IDX_W'(position_in)];
            end
            pal_pkg::OP_LOCATE:
            begin
                // first match within the live part of the list wins
                status_next = pal_pkg::ST_NOTFOUND;
                for (int k = CAP - 1; k >= 0; k--)
                begin
                    if (cell_match[k] && (32'(k) < cnt_w))
                    begin
                        status_next   = pal_pkg::ST_OK;
                        position_next = 4'(k);
                    end
                end
            end
            pal_pkg::OP_CLEAR:
            begin
                do_clear   = 1'b1;
                count_next = '0;
            end
            default:
            begin
                status_next = pal_pkg::ST_OK;
            end
        endcase
    end

    // ---- per-cell actions ---------------------------------------------
    // Slots at or above the length are always zero, so a shift down pulls
    // a zero into the vacated slot; the top slot takes zero explicitly.
    always_comb
    begin
        for (int k = 0; k < CAP; k++)
        begin
            act[k] = pal_pkg::ACT_HOLD;
            if (do_clear)
                act[k] = pal_pkg::ACT_ZERO;
            else if (do_insert)
            begin
                if (32'(k) == pos_w)
                    act[k] = pal_pkg::ACT_LOAD;
                else if (32'(k) > pos_w)
                    act[k] = pal_pkg::ACT_FROM_BELOW;
            end
            else if (do_remove && (32'(k) >= pos_w))
            begin
                if (k == CAP - 1)
                    act[k] = pal_pkg::ACT_ZERO;
                else
                    act[k] = pal_pkg::ACT_FROM_ABOVE;
            end
        end
    end

    // ---- row of slot cells ----------------------------------------------
    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        logic signed [pal_pkg::DATA_W-1:0] lower;
        logic signed [pal_pkg::DATA_W-1:0] upper;

        if (g == 0)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = cell_data[g-1];
        end

        if (g == CAP - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_upper
            assign upper = cell_data[g+1];
        end

        pal_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (accept),
            .act        (act[g]),
            .load_data  (value_in),
            .lower_data (lower),
            .upper_data (upper),
            .key        (value_in),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    // ---- length and output register ---------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            value_reg    <= value_next;
            position_reg <= position_next;
            length_reg   <= 5'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign value_out    = value_reg;
    assign position_out = position_reg;
    assign length_out   = length_reg;

endmodule

FILE: bench/testbench.sv
// ============================================================================
// testbench: positional array list unit
// A queue-fed driver and a clocked monitor run words through the list. The
// monitor keeps its own copy of the store and length, predicts each result as
// the word is taken, and compares every returned word field by field.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

    // codes above clear are unused; the block must answer them and do nothing
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    // quiet stretch: neither side takes random gaps while the tick counter is in here
    localparam int CALM_FROM = 200;
    localparam int CALM_TO   = 520;
    localparam int RANDOM_WORDS = 720;

    // one request word waiting to be driven; hold_off makes the driver wait
    // until every earlier word has returned its result
    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] key;
        logic [4:0]         at;
        bit                 hold_off;
    } list_word_t;

    typedef struct {
        logic [2:0]                 status;
        logic signed [31:0]         value;
        logic [pal_pkg::IDX_W-1:0]  position;
        logic [pal_pkg::CNT_W-1:0]  length;
    } list_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [2:0]          func = pal_pkg::OP_GET;
    logic signed [31:0]  value_in = '0;
    logic [4:0]          position_in = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [2:0]          status;
    logic signed [31:0]  value_out;
    logic [3:0]          position_out;
    logic [4:0]          length_out;

    list_word_t   pending[$];
    list_result_t awaited[$];

    // shadow of the list as the block should hold it
    logic signed [31:0]         slots[pal_pkg::CAPACITY];
    logic [pal_pkg::CNT_W-1:0]  fill = '0;

    // length as the stimulus generator expects it, used to aim positions
    int                  gen_len = 0;
    logic signed [31:0]  key_pool[8];

    int words_sent   = 0;
    int results_seen = 0;
    int faults       = 0;
    int tick         = 0;
    int peak_len     = 0;
    int op_tally[8];
    int st_tally[8];

    positional_array_list_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .value_in     (value_in),
        .position_in  (position_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value_out    (value_out),
        .position_out (position_out),
        .length_out   (length_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction: apply one operation to the shadow list and return the word
    // the block should answer with. Every operation answers exactly once.
    // ------------------------------------------------------------------------
    function automatic list_result_t apply_list_op(logic [2:0] op,
                                                   logic signed [31:0] key,
                                                   logic [4:0] at);
        list_result_t r;
        int           k;
        r.status   = pal_pkg::ST_OK;
        r.value    = '0;
        r.position = '0;
        case (op)
            pal_pkg::OP_INSERT:
            begin
                if (at > fill)
                    r.status = pal_pkg::ST_BADPOS;
                else if (fill == pal_pkg::CAPACITY)
                    r.status = pal_pkg::ST_FULL;
                else
                begin
                    // open a gap at the position, later entries move up
                    for (k = fill; k > at; k--)
                        slots[k] = slots[k - 1];
                    slots[at] = key;
                    fill = fill + pal_pkg::CNT_W'(1);
                end
            end
            pal_pkg::OP_REMOVE:
            begin
                if (fill == 0)
                    r.status = pal_pkg::ST_EMPTY;
                else if (at >= fill)
                    r.status = pal_pkg::ST_BADPOS;
                else
                begin
                    for (k = at; k + 1 < fill; k++)
                        slots[k] = slots[k + 1];
                    slots[fill - 1] = '0;
                    fill = fill - pal_pkg::CNT_W'(1);
                end
            end
            pal_pkg::OP_GET:
            begin
                if (fill == 0)
                    r.status = pal_pkg::ST_EMPTY;
                else if (at >= fill)
                    r.status = pal_pkg::ST_BADPOS;
                else
                    r.value = slots[at];
            end
            pal_pkg::OP_LOCATE:
            begin
                // first match wins; an empty list is simply not found
                r.status = pal_pkg::ST_NOTFOUND;
                for (k = 0; k < fill; k++)
                    if (r.status == pal_pkg::ST_NOTFOUND && slots[k] == key)
                    begin
                        r.status   = pal_pkg::ST_OK;
                        r.position = k[pal_pkg::IDX_W-1:0];
                    end
            end
            pal_pkg::OP_CLEAR:
            begin
                for (k = 0; k < pal_pkg::CAPACITY; k++)
                    slots[k] = '0;
                fill = '0;
            end
            default: ;
        endcase
        r.length = fill;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_word(logic [2:0] op, logic signed [31:0] key,
                                       logic [4:0] at, bit hold_off);
        list_word_t w;
        w.op       = op;
        w.key      = key;
        w.at       = at;
        w.hold_off = hold_off;
        pending.push_back(w);
        case (op)
            pal_pkg::OP_INSERT:
                if (at <= gen_len && gen_len < pal_pkg::CAPACITY) gen_len++;
            pal_pkg::OP_REMOVE:
                if (at < gen_len) gen_len--;
            pal_pkg::OP_CLEAR:
                gen_len = 0;
            default: ;
        endcase
    endfunction

    // extremes, a value already in play (so locate hits and duplicates
    // form), or a fresh random word
    function automatic logic signed [31:0] pick_key(int pool_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return '0;
                default: return -32'sd1;
            endcase
        end
        if (r < 10 + pool_pct)
            return key_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // mode 0 grows the list, 1 churns it, 2 shrinks it; each mode lasts a
    // segment so the list swings between empty and full
    task automatic load_random(int n);
        int          mode;
        int          r;
        int          left;
        bit          hold;
        logic [2:0]  op;
        logic [4:0]  at;
        logic signed [31:0] key;
        int          lim[3][5];
        lim = '{'{60, 72, 84, 97, 98}, '{30, 55, 72, 96, 98}, '{15, 60, 75, 96, 98}};
        mode = 0;
        left = 0;
        hold = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(30, 70);
                if ($urandom_range(0, 2) == 0)
                    hold = 1'b1;
            end
            left--;
            r = $urandom_range(0, 99);
            if (r < lim[mode][0])      op = pal_pkg::OP_INSERT;
            else if (r < lim[mode][1]) op = pal_pkg::OP_REMOVE;
            else if (r < lim[mode][2]) op = pal_pkg::OP_GET;
            else if (r < lim[mode][3]) op = pal_pkg::OP_LOCATE;
            else if (r < lim[mode][4]) op = pal_pkg::OP_CLEAR;
            else                       op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));

            // mostly a position that lands, sometimes anything in range
            at = 5'($urandom_range(0, pal_pkg::CAPACITY));
            if ($urandom_range(0, 99) < 85)
            begin
                if (op == pal_pkg::OP_INSERT)
                    at = 5'($urandom_range(0, gen_len));
                else if (gen_len > 0)
                    at = 5'($urandom_range(0, gen_len - 1));
            end

            key = pick_key(op == pal_pkg::OP_LOCATE ? 60 : 30);
            if (op == pal_pkg::OP_INSERT && $urandom_range(0, 1) == 0)
                key_pool[$urandom_range(0, 7)] = key;
            queue_word(op, key, at, hold);
            hold = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents the head of the pending queue. Valid is held with its
    // payload until the word is taken; gaps come at random except in the
    // quiet stretch. out_ready is stalled on the same terms.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic took;
        logic calm;
        logic gap;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            tick++;
            calm = (tick >= CALM_FROM && tick < CALM_TO);
            gap  = !calm && ($urandom_range(0, 99) < 6);
            took = in_valid && in_ready;
            if (took)
            begin
                pending.delete(0);
                words_sent++;
            end
            if (in_valid && !took)
                ;   // word still on offer, leave it untouched
            else if (pending.size() != 0 && !gap &&
                     !(pending[0].hold_off && words_sent != results_seen))
            begin
                in_valid    <= 1'b1;
                func        <= pending[0].op;
                value_in    <= pending[0].key;
                position_in <= pending[0].at;
            end
            else
                in_valid <= 1'b0;
            out_ready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted request word, then checks every
    // accepted result word against the oldest prediction. Both happen here
    // so the order of always blocks within an edge cannot matter.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, field, want, got);
        faults++;
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = apply_list_op(func, value_in, position_in);
                awaited.push_back(want);
                op_tally[func]++;
                st_tally[want.status]++;
                if (want.length > peak_len)
                    peak_len = want.length;
            end
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, status %0d len %0d",
                             $time, status, length_out);
                    faults++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(status));
                    if (value_out !== want.value)
                        report_mismatch("value_out", want.value, value_out);
                    if (position_out !== want.position)
                        report_mismatch("position_out", 32'(want.position),
                                        32'(position_out));
                    if (length_out !== want.length)
                        report_mismatch("length_out", 32'(want.length), 32'(length_out));
                end
                results_seen <= results_seen + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: directed words first, then the random run, then drain.
    // ------------------------------------------------------------------------
    initial
    begin
        logic signed [31:0] k;
        for (int i = 0; i < pal_pkg::CAPACITY; i++)
            slots[i] = '0;
        for (int i = 0; i < 8; i++)
        begin
            key_pool[i] = $urandom;
            op_tally[i] = 0;
            st_tally[i] = 0;
        end

        // everything refused on an empty list
        queue_word(pal_pkg::OP_GET,    '0, 5'd0, 1'b0);
        queue_word(pal_pkg::OP_REMOVE, '0, 5'd0, 1'b0);
        queue_word(pal_pkg::OP_LOCATE, '0, 5'd0, 1'b0);
        queue_word(pal_pkg::OP_INSERT, '0, 5'd1, 1'b0);

        // fill to capacity with front, middle and end inserts; the value -1
        // goes in twice so locate must return the first copy
        for (int i = 0; i < pal_pkg::CAPACITY; i++)
        begin
            case (i)
                0: k = 32'sh7FFF_FFFF;
                1: k = 32'sh8000_0000;
                2: k = '0;
                3, 4: k = -32'sd1;
                5: k = 32'sh5555_5555;
                6: k = 32'shAAAA_AAAA;
                default: k = $urandom;
            endcase
            queue_word(pal_pkg::OP_INSERT, k, 5'((i * 7) % (i + 1)), 1'b0);
        end
        queue_word(pal_pkg::OP_INSERT, 32'sd12345, 5'd16, 1'b0);   // full list
        queue_word(pal_pkg::OP_GET,    '0, 5'd15, 1'b0);
        queue_word(pal_pkg::OP_GET,    '0, 5'd16, 1'b0);   // position equal to length
        queue_word(pal_pkg::OP_LOCATE, -32'sd1, 5'd0, 1'b0);
        queue_word(pal_pkg::OP_REMOVE, '0, 5'd16, 1'b0);
        queue_word(pal_pkg::OP_REMOVE, '0, 5'd0, 1'b0);
        queue_word(OP_SPARE_A, 32'sh7FFF_FFFF, 5'd3, 1'b0);
        queue_word(OP_SPARE_C, -32'sd1, 5'd31, 1'b0);
        queue_word(pal_pkg::OP_CLEAR,  '0, 5'd0, 1'b0);
        queue_word(pal_pkg::OP_LOCATE, '0, 5'd0, 1'b0);    // zeros gone after clear

        load_random(RANDOM_WORDS);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // sampled away from the active edge so the queues are settled
        @(negedge clk);
        while (pending.size() != 0 || in_valid || awaited.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d words: insert %0d, remove %0d, get %0d, locate %0d",
                 words_sent, op_tally[pal_pkg::OP_INSERT], op_tally[pal_pkg::OP_REMOVE],
                 op_tally[pal_pkg::OP_GET], op_tally[pal_pkg::OP_LOCATE]);
        $display("  clear %0d, unused %0d; peak length %0d",
                 op_tally[pal_pkg::OP_CLEAR],
                 op_tally[OP_SPARE_A] + op_tally[OP_SPARE_B] + op_tally[OP_SPARE_C],
                 peak_len);
        $display("Answers: ok %0d, bad position %0d, empty %0d, full %0d, not found %0d",
                 st_tally[pal_pkg::ST_OK], st_tally[pal_pkg::ST_BADPOS],
                 st_tally[pal_pkg::ST_EMPTY], st_tally[pal_pkg::ST_FULL],
                 st_tally[pal_pkg::ST_NOTFOUND]);
        if (faults == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #1_000_000;
        $display("Timed out with %0d results outstanding", awaited.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pal_pkg.sv
hdl/pal_cell.sv
hdl/positional_array_list_unit.sv
bench/testbench.sv
